[sv/psup_pkg.sv]
// psup_pkg: shared types, widths and constants of the power rail supervisor
// no dependencies; used by every module of the block and by its checker
package psup_pkg;

	// field widths
	localparam int MV_W   = 15;
	localparam int PCT_W  = 7;
	localparam int MODE_W = 2;
	localparam int RAIL_W = 3;
	localparam int BFLT_W = 5;
	localparam int CFLT_W = 8;

	// product of a millivolt value and a percent value
	localparam int PROD_W = MV_W + PCT_W;
	// step counter of the serial multiplier and divider, one step per percent bit
	localparam int CNT_W  = $clog2(PCT_W);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MV_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMPTY_MV  = 2'd0,
		CFG_FULL_MV   = 2'd1,
		CFG_ENTER_PCT = 2'd2,
		CFG_EXIT_PCT  = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [MV_W-1:0]  EMPTY_MV_RST  = 15'd12000;
	localparam logic [MV_W-1:0]  FULL_MV_RST   = 15'd16800;
	localparam logic [PCT_W-1:0] ENTER_PCT_RST = 7'd25;
	localparam logic [PCT_W-1:0] EXIT_PCT_RST  = 7'd30;

	// operating mode and rail codes
	localparam logic [MODE_W-1:0] MODE_PROTECT = 2'd1;
	localparam logic [RAIL_W-1:0] RAILS_ALL    = 3'b111;
	localparam logic [RAIL_W-1:0] RAILS_OFF    = 3'b000;

	// full scale of the charge estimate
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	typedef struct packed {
		logic [MODE_W-1:0] op_mode;
		logic [RAIL_W-1:0] rail_fault_bits;
		logic [RAIL_W-1:0] rail_good_bits;
		logic              charger_link_ok;
		logic              battery_link_ok;
		logic [MV_W-1:0]   pack_millivolts;
		logic [BFLT_W-1:0] battery_fault_bits;
		logic [CFLT_W-1:0] charger_fault_a;
		logic [CFLT_W-1:0] charger_fault_b;
	} tick_t;

	typedef struct packed {
		logic [RAIL_W-1:0] rail_enable_bits;
		logic              supply_ok;
		logic              supply_fault;
		logic              charge_low;
		logic [PCT_W-1:0]  charge_percent;
	} status_t;

endpackage

[sv/power_rail_supervisor.sv]
// A tick with a bad rail or a failed link goes from setup straight to the finish state;
// any other tick passes first through the three bit-serial multipliers and the serial divider.
// A new tick is taken only once the previous one has been loaded into the output register;
// a finished result waits in the output register while the next tick is taken.
// Reset: arst_n clears rails (all off), flags and percent, and loads the default thresholds.
// power_rail_supervisor: top level; depends on psup_pkg, psup_serial_mul, psup_serial_div
module power_rail_supervisor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  psup_pkg::tick_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output psup_pkg::status_t                 result,
	input  logic                              cfg_we,
	input  logic [psup_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psup_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	psup_pkg::tick_t                 item_q;
	logic                            result_valid_q;
	psup_pkg::status_t               result_q;

	// configuration registers
	logic [psup_pkg::MV_W-1:0]       empty_mv_q;
	logic [psup_pkg::MV_W-1:0]       full_mv_q;
	logic [psup_pkg::PCT_W-1:0]      enter_pct_q;
	logic [psup_pkg::PCT_W-1:0]      exit_pct_q;

	// supervisor state
	logic [psup_pkg::RAIL_W-1:0]     rail_on_q;
	logic                            low_q;
	logic                            fault_q;
	logic                            healthy_q;
	logic [psup_pkg::PCT_W-1:0]      pct_q;
	logic [psup_pkg::MV_W-1:0]       span_q;

	logic                            take;
	logic [psup_pkg::RAIL_W-1:0]     bad;
	logic                            link_fail;
	logic                            dev_fault;
	logic [psup_pkg::MV_W-1:0]       span;
	logic [psup_pkg::MV_W-1:0]       level;
	logic                            mul_start;
	logic                            mul_done;
	logic                            enter_done;
	logic                            exit_done;
	logic                            mul_all_done;
	logic                            div_start;
	logic                            div_done;
	logic [psup_pkg::PROD_W-1:0]     prod_level;
	logic [psup_pkg::PROD_W-1:0]     prod_enter;
	logic [psup_pkg::PROD_W-1:0]     prod_exit;
	logic [psup_pkg::PCT_W-1:0]      quotient;
	logic                            load_result;

	logic [psup_pkg::RAIL_W-1:0]     rail_nx;
	logic                            low_nx;
	logic                            fault_nx;
	logic                            healthy_nx;
	logic [psup_pkg::PCT_W-1:0]      pct_nx;
	logic                            low_hyst;

	assign take        = item_valid && !item_stall;
	assign item_stall  = (state_q != ST_IDLE);
	assign load_result = (state_q == ST_FINISH) && (!result_valid_q || !result_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_mv_q  <= psup_pkg::EMPTY_MV_RST;
			full_mv_q   <= psup_pkg::FULL_MV_RST;
			enter_pct_q <= psup_pkg::ENTER_PCT_RST;
			exit_pct_q  <= psup_pkg::EXIT_PCT_RST;
		end else if (cfg_we) begin
			unique case (psup_pkg::cfg_reg_t'(cfg_index))
				psup_pkg::CFG_EMPTY_MV:  empty_mv_q  <= cfg_data;
				psup_pkg::CFG_FULL_MV:   full_mv_q   <= cfg_data;
				psup_pkg::CFG_ENTER_PCT: enter_pct_q <= cfg_data[psup_pkg::PCT_W-1:0];
				psup_pkg::CFG_EXIT_PCT:  exit_pct_q  <= cfg_data[psup_pkg::PCT_W-1:0];
			endcase
		end
	end

	// hold the tick under work
	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= item;
		end
	end

	// tick classification
	assign bad       = (item_q.rail_fault_bits | ~item_q.rail_good_bits) & psup_pkg::RAILS_ALL;
	assign link_fail = !item_q.charger_link_ok || !item_q.battery_link_ok;
	assign dev_fault = (item_q.battery_fault_bits != '0) || (item_q.charger_fault_a != '0)
		|| (item_q.charger_fault_b != '0);

	// span of the voltage window and pack level inside it
	always_comb begin
		span  = psup_pkg::MV_W'(1);
		level = '0;
		if (full_mv_q > empty_mv_q) begin
			span = full_mv_q - empty_mv_q;
			if (item_q.pack_millivolts > empty_mv_q) begin
				level = item_q.pack_millivolts - empty_mv_q;
			end
			if (level > span) begin
				level = span;
			end
		end else begin
			level = psup_pkg::MV_W'(item_q.pack_millivolts >= full_mv_q);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			span_q <= span;
		end
	end

	assign mul_start    = (state_q == ST_SETUP) && (bad == '0) && !link_fail;
	assign mul_all_done = mul_done && enter_done && exit_done;
	assign div_start    = (state_q == ST_MUL) && mul_all_done;

	// scaled level and both thresholds, in parallel
	psup_serial_mul u_mul_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (level),
		.mplier  (psup_pkg::PCT_FULL),
		.product (prod_level),
		.done    (mul_done)
	);

	psup_serial_mul u_mul_enter (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (span),
		.mplier  (enter_pct_q),
		.product (prod_enter),
		.done    (enter_done)
	);

	psup_serial_mul u_mul_exit (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (span),
		.mplier  (exit_pct_q),
		.product (prod_exit),
		.done    (exit_done)
	);

	// percent estimate
	psup_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_level),
		.divisor  (span_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// low-charge hysteresis, set test first
	always_comb begin
		low_hyst = low_q;
		if (prod_level < prod_enter) begin
			low_hyst = 1'b1;
		end else if (prod_level > prod_exit) begin
			low_hyst = 1'b0;
		end
	end

	// supervisor update at the end of a tick
	always_comb begin
		rail_nx    = rail_on_q & ~bad;
		low_nx     = low_q;
		fault_nx   = fault_q;
		healthy_nx = healthy_q;
		pct_nx     = pct_q;
		priority if (bad != '0) begin
			fault_nx   = 1'b1;
			healthy_nx = 1'b0;
		end else if (link_fail) begin
			fault_nx   = 1'b1;
			healthy_nx = 1'b0;
			low_nx     = 1'b1;
			rail_nx    = psup_pkg::RAILS_OFF;
		end else if (dev_fault) begin
			pct_nx     = quotient;
			fault_nx   = 1'b1;
			healthy_nx = 1'b0;
			low_nx     = 1'b1;
			rail_nx    = psup_pkg::RAILS_OFF;
		end else begin
			pct_nx     = quotient;
			fault_nx   = 1'b0;
			healthy_nx = 1'b1;
			low_nx     = low_hyst;
			rail_nx    = (item_q.op_mode == psup_pkg::MODE_PROTECT || low_hyst)
				? psup_pkg::RAILS_OFF : psup_pkg::RAILS_ALL;
		end
	end

	// sequencer, supervisor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
			rail_on_q      <= psup_pkg::RAILS_OFF;
			low_q          <= 1'b0;
			fault_q        <= 1'b0;
			healthy_q      <= 1'b0;
			pct_q          <= '0;
		end else begin
			// output register: load a finished tick, else drop a status once transferred
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= mul_start ? ST_MUL : ST_FINISH;
				end
				ST_MUL: begin
					if (mul_all_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_result) begin
						state_q                   <= ST_IDLE;
						rail_on_q                 <= rail_nx;
						low_q                     <= low_nx;
						fault_q                   <= fault_nx;
						healthy_q                 <= healthy_nx;
						pct_q                     <= pct_nx;
						result_q.rail_enable_bits <= rail_nx;
						result_q.supply_ok        <= healthy_nx;
						result_q.supply_fault     <= fault_nx;
						result_q.charge_low       <= low_nx;
						result_q.charge_percent   <= pct_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[sv/psup_serial_mul.sv]
// psup_serial_mul: shift-and-add multiplier, one multiplier bit per cycle
// depends on psup_pkg for widths
module psup_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psup_pkg::MV_W-1:0]   mcand,
	input  logic [psup_pkg::PCT_W-1:0]  mplier,
	output logic [psup_pkg::PROD_W-1:0] product,
	output logic                        done
);

	localparam logic [psup_pkg::CNT_W-1:0] LAST_STEP = psup_pkg::CNT_W'(psup_pkg::PCT_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [psup_pkg::CNT_W-1:0]    cnt_q;
	logic [psup_pkg::PROD_W-1:0]   acc_q;
	logic [psup_pkg::PROD_W-1:0]   mcand_q;
	logic [psup_pkg::PCT_W-1:0]    mplier_q;

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + psup_pkg::CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate the shifted multiplicand under the low multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= psup_pkg::PROD_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[psup_pkg::PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[psup_pkg::PCT_W-1:1]};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

[sv/psup_serial_div.sv]
// psup_serial_div: restoring divider, one quotient bit per cycle
// depends on psup_pkg for widths; quotient must fit in a percent field
module psup_serial_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psup_pkg::PROD_W-1:0] dividend,
	input  logic [psup_pkg::MV_W-1:0]   divisor,
	output logic [psup_pkg::PCT_W-1:0]  quotient,
	output logic                        done
);

	localparam logic [psup_pkg::CNT_W-1:0] LAST_STEP = psup_pkg::CNT_W'(psup_pkg::PCT_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [psup_pkg::CNT_W-1:0]    cnt_q;
	logic [psup_pkg::PROD_W-1:0]   rem_q;
	logic [psup_pkg::PROD_W-1:0]   dsh_q;
	logic [psup_pkg::PCT_W-1:0]    quo_q;
	logic                          fits;

	assign fits = (rem_q >= dsh_q);

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + psup_pkg::CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// trial subtract of the divisor, walking down from its top position
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= psup_pkg::PROD_W'(divisor) << (psup_pkg::PCT_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[psup_pkg::PCT_W-2:0], fits};
			dsh_q <= {1'b0, dsh_q[psup_pkg::PROD_W-1:1]};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[sv/psup_checker.sv]
// psup_checker: port-level assertions for the power rail supervisor
// depends on psup_pkg; bound to power_rail_supervisor below
module psup_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  logic              result_valid,
	input  logic              result_stall,
	input  psup_pkg::status_t result
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one tick at a time: a transfer closes the input
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input open right after a transfer");

	// healthy and fault never together
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.supply_ok && result.supply_fault))
		else $error("healthy and fault both set");

	// percent stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.charge_percent <= psup_pkg::PCT_FULL)
		else $error("charge percent above full scale");

	// a healthy tick drives all rails together, off while charge is low
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.supply_ok |->
			(result.rail_enable_bits == psup_pkg::RAILS_OFF ||
			 (result.rail_enable_bits == psup_pkg::RAILS_ALL && !result.charge_low)))
		else $error("rails inconsistent with a healthy tick");

endmodule

bind power_rail_supervisor psup_checker u_psup_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[tb/power_rail_supervisor_test.sv]
// power_rail_supervisor_test: self-checking bench for the power rail supervisor
// predicts each status transfer from the tick and threshold registers and checks it in order
// depends on psup_pkg and power_rail_supervisor
module power_rail_supervisor_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MV_MAX       = (1 << psup_pkg::MV_W) - 1;
	localparam int          SETTLE_LIMIT = 5000;
	localparam int          TAIL_CYCLES  = 25;
	localparam int          HOLD_AT      = 150;
	localparam int          HOLD_CYCLES  = 300;
	localparam longint      TIMEOUT_NS   = 4_000_000;

	// mode codes the package leaves unnamed
	localparam logic [psup_pkg::MODE_W-1:0] MODE_NOMINAL = 2'd0;
	localparam logic [psup_pkg::MODE_W-1:0] MODE_PAYLOAD = 2'd2;
	localparam logic [psup_pkg::MODE_W-1:0] MODE_SPARE   = 2'd3;

	// running model of the supervisor plus the queue of status words still owed
	class rail_status_board;
		logic [psup_pkg::MV_W-1:0]   empty_mv;
		logic [psup_pkg::MV_W-1:0]   full_mv;
		logic [psup_pkg::PCT_W-1:0]  enter_pct;
		logic [psup_pkg::PCT_W-1:0]  clear_pct;
		logic [psup_pkg::RAIL_W-1:0] rails;
		logic                        low;
		logic                        fault;
		logic                        healthy;
		logic [psup_pkg::PCT_W-1:0]  percent;
		psup_pkg::status_t           owed_status[$];
		int unsigned                 mismatches;

		function new();
			empty_mv = psup_pkg::EMPTY_MV_RST;
			full_mv = psup_pkg::FULL_MV_RST;
			enter_pct = psup_pkg::ENTER_PCT_RST;
			clear_pct = psup_pkg::EXIT_PCT_RST;
			rails = psup_pkg::RAILS_OFF;
			low = 1'b0;
			fault = 1'b0;
			healthy = 1'b0;
			percent = '0;
			mismatches = 0;
		endfunction

		function void load_register(psup_pkg::cfg_reg_t idx,
				logic [psup_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				psup_pkg::CFG_EMPTY_MV:  empty_mv = value[psup_pkg::MV_W-1:0];
				psup_pkg::CFG_FULL_MV:   full_mv = value[psup_pkg::MV_W-1:0];
				psup_pkg::CFG_ENTER_PCT: enter_pct = value[psup_pkg::PCT_W-1:0];
				psup_pkg::CFG_EXIT_PCT:  clear_pct = value[psup_pkg::PCT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return owed_status.size();
		endfunction

		// one accepted tick: advance the model and queue the status it owes
		function void note_tick(psup_pkg::tick_t t);
			logic [psup_pkg::RAIL_W-1:0] bad;
			int unsigned                 n;
			int unsigned                 d;
			psup_pkg::status_t           s;
			bad = t.rail_fault_bits | ~t.rail_good_bits;
			rails = rails & ~bad;
			if (bad != psup_pkg::RAILS_OFF) begin
				// bad rail: only rails and health flags move
				fault = 1'b1;
				healthy = 1'b0;
			end else if (!t.charger_link_ok || !t.battery_link_ok) begin
				healthy = 1'b0;
				fault = 1'b1;
				low = 1'b1;
				rails = psup_pkg::RAILS_OFF;
			end else begin
				healthy = 1'b1;
				fault = 1'b0;
				// charge estimate, degenerate span steps straight from 0 to 100
				if (full_mv > empty_mv) begin
					d = int'(full_mv) - int'(empty_mv);
					n = (t.pack_millivolts <= empty_mv) ? 0 :
						int'(t.pack_millivolts) - int'(empty_mv);
					if (n > d)
						n = d;
				end else begin
					d = 1;
					n = (t.pack_millivolts >= full_mv) ? 1 : 0;
				end
				// hysteresis, the set test wins
				if (100 * n < int'(enter_pct) * d)
					low = 1'b1;
				else if (100 * n > int'(clear_pct) * d)
					low = 1'b0;
				percent = psup_pkg::PCT_W'((100 * n) / d);
				if (t.battery_fault_bits != '0 || t.charger_fault_a != '0 ||
						t.charger_fault_b != '0) begin
					fault = 1'b1;
					low = 1'b1;
					healthy = 1'b0;
					rails = psup_pkg::RAILS_OFF;
				end else if (t.op_mode == psup_pkg::MODE_PROTECT || low) begin
					rails = psup_pkg::RAILS_OFF;
				end else begin
					rails = psup_pkg::RAILS_ALL;
				end
			end
			s.rail_enable_bits = rails;
			s.supply_ok = healthy;
			s.supply_fault = fault;
			s.charge_low = low;
			s.charge_percent = percent;
			owed_status.push_back(s);
		endfunction

		// one status transfer against the oldest owed status
		function void check_status(psup_pkg::status_t got);
			psup_pkg::status_t want;
			if (owed_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected status: rails %b ok %b flt %b low %b pct %0d",
						$time, got.rail_enable_bits, got.supply_ok, got.supply_fault,
						got.charge_low, got.charge_percent);
				return;
			end
			want = owed_status.pop_front();
			if (got.rail_enable_bits !== want.rail_enable_bits ||
					got.supply_ok !== want.supply_ok ||
					got.supply_fault !== want.supply_fault ||
					got.charge_low !== want.charge_low ||
					got.charge_percent !== want.charge_percent) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: want rails %b ok %b flt %b low %b pct %0d",
						$time, want.rail_enable_bits, want.supply_ok, want.supply_fault,
						want.charge_low, want.charge_percent);
					$display("%0t: got  rails %b ok %b flt %b low %b pct %0d",
						$time, got.rail_enable_bits, got.supply_ok, got.supply_fault,
						got.charge_low, got.charge_percent);
				end
			end
		endfunction
	endclass

	typedef struct {
		int unsigned lo_mv;
		int unsigned hi_mv;
		int unsigned set_pct;
		int unsigned clear_pct;
	} threshold_set_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            item_valid;
	logic                            item_stall;
	psup_pkg::tick_t                 item;
	logic                            result_valid;
	logic                            result_stall;
	psup_pkg::status_t               result;
	logic                            cfg_we;
	logic [psup_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [psup_pkg::CFG_DATA_W-1:0] cfg_data;

	rail_status_board board = new();
	int unsigned      ticks_sent = 0;
	bit               steady = 1'b0;

	power_rail_supervisor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always #10 clk = ~clk;

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("power_rail_supervisor_test: FAIL");
		$finish;
	end

	// status side: random stall, one long hold-off, check each transfer
	initial begin : status_sink
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && ticks_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !steady && ($urandom_range(99) < 14);
			end
			@(negedge clk);
			if (arst_n && result_valid && !result_stall)
				board.check_status(result);
		end
	end

	// one tick transfer, with an occasional gap before it
	task automatic send_tick(input psup_pkg::tick_t t);
		bit taken;
		if (!steady && $urandom_range(99) < 14) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= t;
		do begin
			@(negedge clk);
			taken = !item_stall;
			@(posedge clk);
		end while (!taken);
		board.note_tick(t);
		ticks_sent++;
	endtask

	task automatic put_reg(input psup_pkg::cfg_reg_t idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= psup_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		board.load_register(idx, psup_pkg::CFG_DATA_W'(value));
	endtask

	// wait for every owed status, then let the block go quiet
	task automatic settle();
		int waited;
		item_valid <= 1'b0;
		waited = 0;
		while (board.pending() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// pack voltage aimed at the empty point, the full point, the span between, or anywhere
	function automatic logic [psup_pkg::MV_W-1:0] pick_pack();
		int lo;
		int hi;
		int v;
		lo = int'(board.empty_mv);
		hi = int'(board.full_mv);
		if (lo > hi) begin
			v = lo;
			lo = hi;
			hi = v;
		end
		case ($urandom_range(9))
			0, 1:    v = int'($urandom_range(MV_MAX));
			2, 3:    v = lo + int'($urandom_range(80)) - 40;
			4, 5:    v = hi + int'($urandom_range(80)) - 40;
			default: v = int'($urandom_range(hi, lo));
		endcase
		if (v < 0)
			v = 0;
		if (v > MV_MAX)
			v = MV_MAX;
		return psup_pkg::MV_W'(v);
	endfunction

	function automatic psup_pkg::tick_t good_tick(input logic [psup_pkg::MODE_W-1:0] mode,
			input int unsigned pack);
		psup_pkg::tick_t t;
		t = '0;
		t.op_mode = mode;
		t.rail_good_bits = psup_pkg::RAILS_ALL;
		t.charger_link_ok = 1'b1;
		t.battery_link_ok = 1'b1;
		t.pack_millivolts = psup_pkg::MV_W'(pack);
		return t;
	endfunction

	// mostly clean ticks, then faults, link loss, bad rails and raw noise
	function automatic psup_pkg::tick_t random_tick();
		psup_pkg::tick_t t;
		logic [63:0]     noise;
		int unsigned     kind;
		kind = $urandom_range(99);
		t = good_tick(psup_pkg::MODE_W'($urandom_range(3)), pick_pack());
		if (kind < 62) begin
			t.op_mode = psup_pkg::MODE_W'($urandom_range(3));
		end else if (kind < 72) begin
			case ($urandom_range(2))
				0:       t.battery_fault_bits = psup_pkg::BFLT_W'($urandom_range(1, 31));
				1:       t.charger_fault_a = psup_pkg::CFLT_W'($urandom_range(1, 255));
				default: t.charger_fault_b = psup_pkg::CFLT_W'($urandom_range(1, 255));
			endcase
		end else if (kind < 80) begin
			case ($urandom_range(2))
				0:       t.charger_link_ok = 1'b0;
				1:       t.battery_link_ok = 1'b0;
				default: begin
					t.charger_link_ok = 1'b0;
					t.battery_link_ok = 1'b0;
				end
			endcase
			t.battery_fault_bits = psup_pkg::BFLT_W'($urandom);
		end else if (kind < 92) begin
			do begin
				t.rail_fault_bits = psup_pkg::RAIL_W'($urandom);
				t.rail_good_bits = psup_pkg::RAIL_W'($urandom);
			end while ((t.rail_fault_bits | ~t.rail_good_bits) == psup_pkg::RAILS_OFF);
		end else begin
			noise = {$urandom, $urandom};
			t = noise[$bits(psup_pkg::tick_t)-1:0];
		end
		return t;
	endfunction

	// stimulus
	initial begin : stimulus
		psup_pkg::tick_t opening[$];
		psup_pkg::tick_t t;
		threshold_set_t  phases[$];
		int              rounds;

		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= psup_pkg::CFG_EMPTY_MV;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks on the reset thresholds (12000 to 16800 mV, 25/30 percent)
		opening.push_back('0);
		opening.push_back('1);
		opening.push_back(good_tick(MODE_NOMINAL, 16800));
		t = good_tick(MODE_NOMINAL, 16800);
		t.rail_fault_bits = 3'b001;
		opening.push_back(t);
		t = good_tick(MODE_NOMINAL, 16800);
		t.rail_good_bits = 3'b101;
		opening.push_back(t);
		t = good_tick(MODE_NOMINAL, 16800);
		t.rail_fault_bits = 3'b100;
		opening.push_back(t);
		opening.push_back(good_tick(MODE_PAYLOAD, MV_MAX));
		opening.push_back(good_tick(psup_pkg::MODE_PROTECT, 15000));
		opening.push_back(good_tick(MODE_NOMINAL, 0));
		// bad rail keeps low flag and percent
		t = good_tick(MODE_NOMINAL, 16800);
		t.rail_good_bits = 3'b011;
		opening.push_back(t);
		// exactly at the clear point, then just past it
		opening.push_back(good_tick(MODE_NOMINAL, 13440));
		opening.push_back(good_tick(MODE_SPARE, 13441));
		// exactly at the set point, then just below it
		opening.push_back(good_tick(MODE_NOMINAL, 13200));
		opening.push_back(good_tick(MODE_NOMINAL, 13199));
		t = good_tick(MODE_NOMINAL, 16000);
		t.charger_link_ok = 1'b0;
		opening.push_back(t);
		t = good_tick(MODE_NOMINAL, 16000);
		t.battery_link_ok = 1'b0;
		opening.push_back(t);
		t = good_tick(MODE_NOMINAL, 16000);
		t.charger_link_ok = 1'b0;
		t.battery_link_ok = 1'b0;
		opening.push_back(t);
		opening.push_back(good_tick(MODE_NOMINAL, 16000));
		// pack faults still update the percent
		t = good_tick(MODE_NOMINAL, 15000);
		t.battery_fault_bits = 5'h10;
		opening.push_back(t);
		t = good_tick(MODE_NOMINAL, 14000);
		t.charger_fault_a = 8'h80;
		opening.push_back(t);
		t = good_tick(MODE_NOMINAL, 15500);
		t.charger_fault_b = 8'h01;
		opening.push_back(t);
		opening.push_back(good_tick(MODE_NOMINAL, 12000));
		opening.push_back(good_tick(MODE_PAYLOAD, 16000));
		foreach (opening[i])
			send_tick(opening[i]);

		// threshold settings: widest span, equal points, reversed points,
		// reset values, random, one-millivolt span, narrow span at zero
		phases.push_back('{12000, 16800, 25, 30});
		phases.push_back('{0, MV_MAX, 0, 127});
		phases.push_back('{MV_MAX, MV_MAX, 127, 100});
		phases.push_back('{20000, 10000, 50, 40});
		phases.push_back('{12000, 16800, 25, 30});
		phases.push_back('{$urandom_range(MV_MAX), $urandom_range(1, MV_MAX),
			$urandom_range(127), $urandom_range(127)});
		phases.push_back('{100, 101, 100, 0});
		phases.push_back('{0, 1, 99, 100});

		foreach (phases[p]) begin
			if (p != 0) begin
				settle();
				put_reg(psup_pkg::CFG_EMPTY_MV, phases[p].lo_mv);
				put_reg(psup_pkg::CFG_FULL_MV, phases[p].hi_mv);
				put_reg(psup_pkg::CFG_ENTER_PCT, phases[p].set_pct);
				put_reg(psup_pkg::CFG_EXIT_PCT, phases[p].clear_pct);
				cfg_we <= 1'b0;
			end
			// one stretch with no idling on either side
			steady = (p == 4);
			rounds = (p == 0) ? 230 : 130;
			repeat (rounds)
				send_tick(random_tick());
		end
		steady = 1'b0;

		settle();
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("power_rail_supervisor_test: PASS");
		end else begin
			$display("power_rail_supervisor_test: FAIL");
		end
		$finish;
	end

endmodule

[power_rail_supervisor.f]
sv/psup_pkg.sv
sv/psup_serial_mul.sv
sv/psup_serial_div.sv
sv/power_rail_supervisor.sv
sv/psup_checker.sv
tb/power_rail_supervisor_test.sv
